// ===== rtl/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

  // Field widths of the stream beats
  localparam int unsigned ReqW    = 18;
  localparam int unsigned FirstW  = 11;
  localparam int unsigned CountW  = 12;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  // Megabytes per block as a shift: a block is 64 megabytes
  localparam int unsigned MbShift = 6;
  localparam int unsigned NeedW   = ReqW - MbShift;

  // Default map size and widest segment one cell holds
  localparam int unsigned NumBlocksDef = 2048;
  localparam int unsigned SegBitsMax   = 32;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  // Controls from the sequencer to every cell of the ring
  typedef struct packed {
    logic clear;
    logic mark;
    logic shift;
  } cell_ctl_t;

  // Controls from the sequencer to the scan head
  typedef struct packed {
    logic init;
    logic step;
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ffba_cell.sv =====
`default_nettype none

module ffba_cell #(
  parameter int unsigned SegBits = 32,
  parameter int unsigned CntW    = 12,
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ffba_pkg::cell_ctl_t   ctl_i,
  input  wire logic [SegBits-1:0]    nbr_i,   // segment from the next cell
  input  wire logic [CntW-1:0]       lo_i,    // first block to mark
  input  wire logic [CntW-1:0]       hi_i,    // one past the last block to mark
  output logic      [SegBits-1:0]    word_o
);
  import ffba_pkg::*;

  localparam int unsigned SegW1 = SegBits + 1;
  localparam int unsigned SegLW = $clog2(SegBits) + 1;
  localparam logic [CntW-1:0] BaseC = CntW'(CellIdx * SegBits);
  localparam logic [CntW-1:0] SegC  = CntW'(SegBits);

  logic [SegBits-1:0] bits_q, bits_d;
  logic [SegLW-1:0]   lo_l, hi_l;
  logic [SegW1-1:0]   ones_lo, ones_hi;
  logic [CntW-1:0]    lo_rel, hi_rel;

  // Clip the mark range to this cell's segment
  always_comb begin
    lo_rel = lo_i - BaseC;
    hi_rel = hi_i - BaseC;
    if (lo_i <= BaseC) begin
      lo_l = '0;
    end else if (lo_rel >= SegC) begin
      lo_l = SegLW'(SegBits);
    end else begin
      lo_l = SegLW'(lo_rel);
    end
    if (hi_i <= BaseC) begin
      hi_l = '0;
    end else if (hi_rel >= SegC) begin
      hi_l = SegLW'(SegBits);
    end else begin
      hi_l = SegLW'(hi_rel);
    end
    ones_lo = (SegW1'(1) << lo_l) - SegW1'(1);
    ones_hi = (SegW1'(1) << hi_l) - SegW1'(1);
  end

  // Clear, mark in place, or pass the segment down the ring
  always_comb begin
    bits_d = bits_q;
    if (ctl_i.clear) begin
      bits_d = '0;
    end else if (ctl_i.mark) begin
      bits_d = bits_q | ones_hi[SegBits-1:0] & ~ones_lo[SegBits-1:0];
    end else if (ctl_i.shift) begin
      bits_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  assign word_o = bits_q;

endmodule

`default_nettype wire

// ===== rtl/ffba_scan.sv =====
`default_nettype none

module ffba_scan #(
  parameter int unsigned NumBlocks = 2048,
  parameter int unsigned SegBits   = 32,
  parameter int unsigned IdxW      = $clog2(NumBlocks),
  parameter int unsigned CntW      = IdxW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ffba_pkg::scan_ctl_t  ctl_i,
  input  wire logic [SegBits-1:0]   word_i,   // segment at the head of the ring
  input  wire logic [CntW-1:0]      need_i,
  output logic                      found_o,
  output logic      [IdxW-1:0]      start_o,
  output logic                      last_o
);
  import ffba_pkg::*;

  localparam int unsigned NumCells = NumBlocks / SegBits;
  localparam int unsigned SegIdxW  = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int unsigned SegLog   = $clog2(SegBits);
  localparam int unsigned SegW1    = SegBits + 1;

  logic [SegIdxW-1:0] seg_q, seg_d;
  logic [CntW-1:0]    run_q, run_d;
  logic               found_q, found_d;
  logic [IdxW-1:0]    start_q, start_d;

  logic [SegBits-1:0] hit;
  logic [CntW-1:0]    base;
  logic [CntW-1:0]    tail;
  logic               any_used;
  logic [CntW-1:0]    run_next;
  logic [CntW-1:0]    hit_pos;
  logic [CntW-1:0]    start_calc;

  // Per block of the head segment: does a free run of need_i end here
  always_comb begin
    logic [SegW1-1:0] word_ext;
    logic [SegW1-1:0] ones_a;
    logic [SegW1-1:0] ones_b;
    logic [CntW-1:0]  jp1;
    word_ext = {1'b0, word_i};
    hit      = '0;
    for (int j = 0; j < SegBits; j++) begin
      jp1    = CntW'(j + 1);
      ones_a = (SegW1'(1) << jp1) - SegW1'(1);
      ones_b = '0;
      if (need_i <= jp1) begin
        ones_b = (SegW1'(1) << (jp1 - need_i)) - SegW1'(1);
        hit[j] = ((word_ext & (ones_a ^ ones_b)) == '0);
      end else begin
        hit[j] = ((word_ext & ones_a) == '0) && ((run_q + jp1) >= need_i);
      end
    end
  end

  // Free run left open at the top of the segment
  always_comb begin
    tail     = '0;
    any_used = 1'b0;
    for (int j = 0; j < SegBits; j++) begin
      if (word_i[j]) begin
        tail     = CntW'(SegBits - 1 - j);
        any_used = 1'b1;
      end
    end
    run_next = any_used ? tail : run_q + CntW'(SegBits);
  end

  // Lowest block where the run completes, and where that run starts
  always_comb begin
    hit_pos = '0;
    for (int j = SegBits - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_pos = CntW'(j + 1);
      end
    end
    base       = CntW'(seg_q) << SegLog;
    start_calc = base + hit_pos - need_i;
  end

  // Advance the scan by one segment
  always_comb begin
    seg_d   = seg_q;
    run_d   = run_q;
    found_d = found_q;
    start_d = start_q;
    if (ctl_i.init) begin
      seg_d   = '0;
      run_d   = '0;
      found_d = 1'b0;
      start_d = '0;
    end else if (ctl_i.step) begin
      seg_d = (NumCells > 1) ? seg_q + SegIdxW'(1) : '0;
      if (!found_q) begin
        if (|hit) begin
          found_d = 1'b1;
          start_d = IdxW'(start_calc);
        end else begin
          run_d = run_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
      start_q <= '0;
    end else begin
      seg_q   <= seg_d;
      run_q   <= run_d;
      found_q <= found_d;
      start_q <= start_d;
    end
  end

  assign found_o = found_q;
  assign start_o = start_q;
  assign last_o  = (seg_q == SegIdxW'(NumCells - 1));

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator_unit.sv =====
// Flow: a clear, or a request of no block or of more blocks than the map
//   holds, goes from the decode straight to the result stage; a real request
//   first steps the ring of cells of up to 32 blocks once past the scan head,
//   one cell per step, then marks the run found and then unloads the result.
// Throughput: one item at a time; the next beat is taken once the result sits
//   in the output register. Reset clears the whole map (every block free).
`default_nettype none

module first_fit_block_allocator_unit #(
  // Map size: a power of two from 16 to 2048
  parameter int unsigned NumBlocks = ffba_pkg::NumBlocksDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [ffba_pkg::InDataW-1:0]    s_axis_tdata_i,   // [17:0] request_mbytes
  input  wire logic                            s_axis_tuser_i,   // [0] command
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [ffba_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [10:0] first_block,
                                                                 // [22:11] block_count
  output logic                                 m_axis_tuser_o    // [0] granted
);
  import ffba_pkg::*;

  localparam int unsigned SegBits  = (NumBlocks < SegBitsMax) ? NumBlocks : SegBitsMax;
  localparam int unsigned NumCells = NumBlocks / SegBits;
  localparam int unsigned IdxW     = $clog2(NumBlocks);
  localparam int unsigned CntW     = IdxW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       need_q;
  logic                  res_grant_q;
  logic [FirstW-1:0]     res_first_q;
  logic [CountW-1:0]     res_count_q;
  logic                  m_valid_q;
  logic                  m_user_q;
  logic [OutDataW-1:0]   m_data_q;

  logic                  in_fire;
  logic                  out_free;
  logic [NeedW-1:0]      need_raw;
  cmd_e                  cmd;
  cell_ctl_t             cell_ctl;
  scan_ctl_t             scan_ctl;
  logic                  found;
  logic [IdxW-1:0]       start;
  logic                  last_seg;
  logic [CntW-1:0]       mark_lo, mark_hi;
  logic [SegBits-1:0]    words [NumCells];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign need_raw        = s_axis_tdata_i[ReqW-1:MbShift];
  assign cmd             = cmd_e'(s_axis_tuser_i);

  // Drive the ring and the scan head from the sequencer state
  always_comb begin
    cell_ctl.clear = in_fire && (cmd == CMD_CLEAR);
    cell_ctl.shift = (state_q == S_SCAN);
    cell_ctl.mark  = (state_q == S_MARK) && found;
    scan_ctl.init  = in_fire;
    scan_ctl.step  = (state_q == S_SCAN);
    mark_lo        = CntW'(start);
    mark_hi        = CntW'(start) + need_q;
  end

  // Ring of cells, each passing its segment to the one below
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    ffba_cell #(
      .SegBits (SegBits),
      .CntW    (CntW),
      .CellIdx (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .nbr_i  (words[(k + 1) % NumCells]),
      .lo_i   (mark_lo),
      .hi_i   (mark_hi),
      .word_o (words[k])
    );
  end

  ffba_scan #(
    .NumBlocks (NumBlocks),
    .SegBits   (SegBits),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .word_i  (words[0]),
    .need_i  (need_q),
    .found_o (found),
    .start_o (start),
    .last_o  (last_seg)
  );

  // Sequence one item: decode, scan, mark, hand over the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      need_q      <= '0;
      res_grant_q <= 1'b0;
      res_first_q <= '0;
      res_count_q <= '0;
      m_valid_q   <= 1'b0;
      m_user_q    <= 1'b0;
      m_data_q    <= '0;
    end else begin
      if (m_axis_tready_i && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_first_q <= '0;
            res_count_q <= '0;
            need_q      <= CntW'(need_raw);
            if (cmd == CMD_CLEAR) begin
              res_grant_q <= 1'b1;
              state_q     <= S_DONE;
            end else if (need_raw == '0) begin
              res_grant_q <= 1'b1;
              state_q     <= S_DONE;
            end else if (32'(need_raw) > 32'(NumBlocks)) begin
              res_grant_q <= 1'b0;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (last_seg) begin
            state_q <= S_MARK;
          end
        end
        S_MARK: begin
          res_grant_q <= found;
          res_first_q <= found ? FirstW'(start) : '0;
          res_count_q <= found ? CountW'(need_q) : '0;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_grant_q;
            m_data_q  <= OutDataW'({res_count_q, res_first_q});
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  localparam int unsigned MapBlocks   = NumBlocksDef;
  localparam int unsigned MbPerBlock  = 64;
  localparam int unsigned RandomJobs  = 950;
  localparam int unsigned QuietTail   = 100;
  localparam int unsigned SettleTicks = 100;
  localparam int unsigned TickLimit   = 500000;

  // One request beat: command in tuser, size in tdata
  typedef struct packed {
    cmd_e            cmd;
    logic [ReqW-1:0] mbytes;
  } alloc_job_t;

  // One grant beat
  typedef struct packed {
    logic              granted;
    logic [FirstW-1:0] first_block;
    logic [CountW-1:0] block_count;
  } grant_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  alloc_job_t job_queue[$];
  grant_t     grants_due[$];
  alloc_job_t job_on_bus;
  bit         block_taken [MapBlocks];
  int         fault_count = 0;
  int         send_gap    = 0;
  int         take_stall  = 0;
  int         tick_count  = 0;

  first_fit_block_allocator_unit #(
    .NumBlocks(MapBlocks)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [17:0] request_mbytes
    .s_axis_tuser_i (s_axis_tuser_i),   // [0] command
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // [10:0] first_block, [22:11] block_count
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] granted
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // First-fit placement over the shadow map; a clear frees the whole map
  function automatic grant_t place_job(alloc_job_t job);
    grant_t g;
    int     need;
    int     run;
    g = '0;
    if (job.cmd == CMD_CLEAR) begin
      for (int b = 0; b < MapBlocks; b++) block_taken[b] = 1'b0;
      g.granted = 1'b1;
      return g;
    end
    need = int'(job.mbytes) / MbPerBlock;
    if (need == 0) begin
      g.granted = 1'b1;
      return g;
    end
    if (need > MapBlocks) return g;
    run = 0;
    for (int b = 0; b < MapBlocks; b++) begin
      if (block_taken[b]) begin
        run = 0;
      end else begin
        run++;
        if (run == need) begin
          for (int k = b + 1 - need; k <= b; k++) block_taken[k] = 1'b1;
          g.granted     = 1'b1;
          g.first_block = FirstW'(b + 1 - need);
          g.block_count = CountW'(need);
          return g;
        end
      end
    end
    return g;
  endfunction

  task automatic queue_job(cmd_e cmd, int unsigned mbytes);
    alloc_job_t job;
    job.cmd    = cmd;
    job.mbytes = ReqW'(mbytes);
    job_queue.push_back(job);
  endtask

  // Feed request beats, with random idle bursts outside the tail
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    alloc_job_t next_job;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
      send_gap        <= 0;
    end else begin
      // predict on acceptance
      if (s_axis_tvalid_i && s_axis_tready_o) grants_due.push_back(place_job(job_on_bus));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap        <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (job_queue.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (job_queue.size() > QuietTail && $urandom_range(0, 7) == 0) begin
          send_gap        <= $urandom_range(0, 3);
          s_axis_tvalid_i <= 1'b0;
        end else begin
          next_job        = job_queue.pop_front();
          job_on_bus      <= next_job;
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {{(InDataW - ReqW){1'b0}}, next_job.mbytes};
          s_axis_tuser_i  <= next_job.cmd;
        end
      end
    end
  end

  // Check grant beats against the oldest prediction; stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin : check_grants
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      take_stall      <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.granted     = m_axis_tuser_o;
        got.first_block = m_axis_tdata_o[FirstW-1:0];
        got.block_count = m_axis_tdata_o[FirstW+CountW-1:FirstW];
        if (grants_due.size() == 0) begin
          $error("grant beat with nothing expected: granted %0d first_block %0d block_count %0d",
                 got.granted, got.first_block, got.block_count);
          fault_count++;
        end else begin
          want = grants_due.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            fault_count++;
          end
          if (got.first_block !== want.first_block) begin
            $error("first_block: expected %0d, actual %0d", want.first_block, got.first_block);
            fault_count++;
          end
          if (got.block_count !== want.block_count) begin
            $error("block_count: expected %0d, actual %0d", want.block_count, got.block_count);
            fault_count++;
          end
        end
      end
      if (take_stall > 0) begin
        take_stall      <= take_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else if (job_queue.size() > QuietTail && $urandom_range(0, 9) == 0) begin
        take_stall      <= $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    tick_count <= tick_count + 1;
    if (tick_count == TickLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_jobs
    int unsigned pick;
    int unsigned n;
    // directed: edges of the size field, full map, overflow, clears
    queue_job(CMD_CLEAR, 0);
    queue_job(CMD_ALLOC, 0);
    queue_job(CMD_ALLOC, 63);
    queue_job(CMD_ALLOC, 64);
    queue_job(CMD_ALLOC, 127);
    queue_job(CMD_ALLOC, 128);
    queue_job(CMD_ALLOC, 262143);
    queue_job(CMD_ALLOC, 131136);
    queue_job(CMD_ALLOC, 131072);
    queue_job(CMD_ALLOC, 2044 * 64);
    queue_job(CMD_ALLOC, 64);
    queue_job(CMD_ALLOC, 0);
    queue_job(CMD_CLEAR, 262143);
    queue_job(CMD_ALLOC, 131072);
    queue_job(CMD_CLEAR, 0);
    queue_job(CMD_ALLOC, 1000 * 64);
    queue_job(CMD_ALLOC, 1048 * 64 + 63);
    queue_job(CMD_ALLOC, 64);
    queue_job(CMD_CLEAR, 0);
    queue_job(CMD_ALLOC, 'h2AAAA);
    queue_job(CMD_ALLOC, 'h15555);
    queue_job(CMD_CLEAR, 'h2AAAA);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hold off until the directed part has fully drained
    @(posedge clk_i);
    while (job_queue.size() != 0 || s_axis_tvalid_i || grants_due.size() != 0)
      @(posedge clk_i);

    // random batches: mostly small requests that fill the map, some large,
    // a few zero-block, raw and clear beats
    for (n = 0; n < RandomJobs; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        queue_job(CMD_CLEAR, $urandom_range(0, 262143));
      else if (pick < 8)
        queue_job(CMD_ALLOC, $urandom_range(0, 63));
      else if (pick < 13)
        queue_job(CMD_ALLOC, $urandom_range(0, 262143));
      else if (pick < 18)
        queue_job(CMD_ALLOC, $urandom_range(128, 2048) * 64 + $urandom_range(0, 63));
      else
        queue_job(CMD_ALLOC, $urandom_range(1, 48) * 64 + $urandom_range(0, 63));
    end

    // drain, then let any stray beat show up
    while (job_queue.size() != 0 || s_axis_tvalid_i || grants_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== first_fit_block_allocator_unit.f =====
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/ffba_scan.sv
rtl/first_fit_block_allocator_unit.sv
sim/testbench.sv
